// ----- src/ppta_pkg.sv -----
`default_nettype none
package ppta_pkg;

  // Table size and internal time width.
  localparam int NUM_PROCS = 256;
  localparam int TIME_BITS = 48;
  localparam int IDX_BITS  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  // Request types.
  typedef enum logic [2:0] {
    REQ_START     = 3'd0,
    REQ_PLAY      = 3'd1,
    REQ_MPI_PAUSE = 3'd2,
    REQ_TRC_PAUSE = 3'd3,
    REQ_END       = 3'd4
  } req_kind_t;

  // Mode classes kept per process.
  typedef enum logic [2:0] {
    MC_USEFUL   = 3'd0,
    MC_MPI      = 3'd1,
    MC_END      = 3'd2,
    MC_DISABLED = 3'd3,
    MC_FLUSH    = 3'd4,
    MC_INIT     = 3'd5,
    MC_INVALID  = 3'd6
  } mode_t;

  // First-error codes.
  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_PLAY_EV   = 3'd1,
    ERR_UNTRACED  = 3'd2,
    ERR_REPAUSED  = 3'd3,
    ERR_AFTER_END = 3'd4,
    ERR_INVALID   = 3'd5,
    ERR_UNKNOWN   = 3'd6,
    ERR_REENABLE  = 3'd7
  } err_t;

  // Event codes.
  localparam logic signed [15:0] EV_USEFUL  = 16'sd0;
  localparam logic signed [15:0] EV_END     = -16'sd1;
  localparam logic signed [15:0] EV_DISABLE = -16'sd2;
  localparam logic signed [15:0] EV_FLUSH   = -16'sd3;
  localparam logic signed [15:0] EV_INIT    = -16'sd4;
  localparam logic signed [15:0] EV_INVALID = -16'sd99;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         proc;
    logic [47:0]        stamp;
    logic signed [15:0] event_code;
    logic [47:0]        trace_begin;
    logic [47:0]        universe_end;
  } req_t;

  typedef struct packed {
    logic [47:0] elapsed_out;
    logic [47:0] traced_out;
    logic [47:0] flush_out;
    logic [47:0] useful_out;
    logic [47:0] critical_out;
    logic [2:0]  error_code;
  } rsp_t;

  // One table entry.
  typedef struct packed {
    mode_t mode;
    time_t since;
    logic  tr_on;
    time_t tr_time;
    time_t elapsed;
    time_t traced;
    time_t flush;
    time_t useful;
    time_t critical;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    mode: MC_USEFUL, since: '0, tr_on: 1'b1, tr_time: '0, elapsed: '0,
    traced: '0, flush: '0, useful: '0, critical: '0
  };

  // Table write port.
  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } mem_wr_t;

endpackage
`default_nettype wire

// ----- src/ppta_mem.sv -----
`default_nettype none
module ppta_mem (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire ppta_pkg::idx_t   rd_addr,
  output ppta_pkg::entry_t      rd_data,
  input  wire ppta_pkg::mem_wr_t wr
);
  import ppta_pkg::*;

  entry_t              mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] valid;
  entry_t              rd_raw;
  logic                rd_valid;

  // Entry storage, registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Written flags; an entry never written reads as its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : ENTRY_RESET;

endmodule
`default_nettype wire

// ----- src/ppta_update.sv -----
`default_nettype none
module ppta_update (
  input  wire ppta_pkg::req_t   req,
  input  wire ppta_pkg::entry_t ent,
  output ppta_pkg::entry_t      ent_next,
  output logic                  wr_en,
  output ppta_pkg::rsp_t        rsp
);
  import ppta_pkg::*;

  function automatic mode_t class_of(logic signed [15:0] e);
    mode_t m;
    if (e == EV_USEFUL)        m = MC_USEFUL;
    else if (!e[15])           m = MC_MPI;
    else if (e == EV_END)      m = MC_END;
    else if (e == EV_DISABLE)  m = MC_DISABLED;
    else if (e == EV_FLUSH)    m = MC_FLUSH;
    else if (e == EV_INIT)     m = MC_INIT;
    else if (e == EV_INVALID)  m = MC_INVALID;
    else                       m = MC_MPI;
    return m;
  endfunction

  time_t  t, tb, ue, d, ue_d;
  logic   in_range;
  err_t   err;
  entry_t n;
  logic   cr_useful, cr_flush, cr_end;

  assign t  = TIME_BITS'(req.stamp);
  assign tb = TIME_BITS'(req.trace_begin);
  assign ue = TIME_BITS'(req.universe_end);
  assign d    = t - ent.since;
  assign ue_d = ue - t;
  assign in_range = int'(req.proc) < NUM_PROCS;

  // Credit conditions for the mode being left.
  assign cr_useful = (ent.mode == MC_USEFUL) && ent.tr_on;
  assign cr_flush  = (ent.mode == MC_FLUSH);
  assign cr_end    = (ent.mode == MC_END);

  always_comb begin
    n     = ent;
    err   = ERR_OK;
    wr_en = in_range;
    case (req.req_type)
      REQ_START: begin
        if (ent.tr_on && (ent.tr_time != tb)) err = ERR_REENABLE;
        n.tr_on    = 1'b1;
        n.tr_time  = tb;
        n.critical = t;
        n.traced   = t;
        n.mode     = MC_USEFUL;
      end
      REQ_PLAY, REQ_MPI_PAUSE, REQ_TRC_PAUSE: begin
        // Errors raised before the credit take priority.
        if (req.req_type == REQ_PLAY) begin
          if (req.event_code != EV_USEFUL) err = ERR_PLAY_EV;
        end else if (req.req_type == REQ_MPI_PAUSE) begin
          if (!ent.tr_on) err = ERR_UNTRACED;
          else if ((ent.mode != MC_USEFUL) && (t != ent.since)) err = ERR_REPAUSED;
        end
        if (cr_useful) begin
          n.critical = ent.critical + d;
          n.useful   = ent.useful + d;
        end else if (cr_flush) begin
          n.flush = ent.flush + d;
        end else if (cr_end && (err == ERR_OK)) begin
          err = ERR_AFTER_END;
        end
        if (ent.tr_on) n.traced = ent.traced + d;
        // Tracing changes after the credit.
        if (req.req_type == REQ_PLAY) begin
          if (!ent.tr_on) begin
            n.tr_on   = 1'b1;
            n.tr_time = t;
          end
        end else if (req.req_type == REQ_TRC_PAUSE) begin
          if (req.event_code == EV_INVALID) begin
            if (err == ERR_OK) err = ERR_INVALID;
          end else if (req.event_code == EV_DISABLE) begin
            if (ent.tr_on) begin
              n.tr_on   = 1'b0;
              n.tr_time = t;
            end
          end else if ((req.event_code != EV_END) && (req.event_code != EV_FLUSH) &&
                       (req.event_code != EV_INIT)) begin
            if (err == ERR_OK) err = ERR_UNKNOWN;
          end
        end
        n.mode = class_of(req.event_code);
      end
      REQ_END: begin
        if (ent.mode == MC_USEFUL) n.useful = ent.useful + d;
        else if (ent.mode == MC_DISABLED) n.useful = ent.useful + ue_d;
        n.critical = ent.critical + d;
        n.traced   = ent.traced + d;
        n.mode     = MC_END;
      end
      default: begin
        err   = ERR_UNKNOWN;
        wr_en = 1'b0;
      end
    endcase
    // Every handled request enters its new mode at the event time.
    if (wr_en) begin
      n.since   = t;
      n.elapsed = t;
    end
    ent_next = n;
  end

  // Result fields: counters after the update, zero for an unknown process.
  always_comb begin
    if (in_range) begin
      rsp.elapsed_out  = 48'(ent_next.elapsed);
      rsp.traced_out   = 48'(ent_next.traced);
      rsp.flush_out    = 48'(ent_next.flush);
      rsp.useful_out   = 48'(ent_next.useful);
      rsp.critical_out = 48'(ent_next.critical);
      rsp.error_code   = err;
    end else begin
      rsp.elapsed_out  = '0;
      rsp.traced_out   = '0;
      rsp.flush_out    = '0;
      rsp.useful_out   = '0;
      rsp.critical_out = '0;
      rsp.error_code   = ERR_UNKNOWN;
    end
  end

endmodule
`default_nettype wire

// ----- src/per_process_time_accounting.sv -----
`default_nettype none
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     ppta_pkg::req_t
// rsp       out        rsp_valid / rsp_ready     ppta_pkg::rsp_t
//
// On acceptance in ST_IDLE the table read is issued; in ST_CALC the entry is
// updated from the registered read data and written back when the result is
// loaded into the output register. Reset clears the written flags at once, so
// every entry reads as its reset value right after reset. A result waiting in
// the output register holds the update back until it is taken; no new item is
// accepted meanwhile.
module per_process_time_accounting (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire ppta_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output ppta_pkg::rsp_t      rsp
);
  import ppta_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t  state;
  req_t    req_q;
  entry_t  rd_data;
  entry_t  ent_next;
  logic    upd_wr;
  rsp_t    rsp_calc;
  mem_wr_t wr;
  logic    req_acc;
  logic    load;

  assign req_ready = (state == ST_IDLE);
  assign req_acc   = req_valid && req_ready;
  assign load      = (state == ST_CALC) && (!rsp_valid || rsp_ready);

  ppta_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (req_acc),
    .rd_addr (IDX_BITS'(req.proc)),
    .rd_data (rd_data),
    .wr      (wr)
  );

  ppta_update u_update (
    .req      (req_q),
    .ent      (rd_data),
    .ent_next (ent_next),
    .wr_en    (upd_wr),
    .rsp      (rsp_calc)
  );

  // Write back in the cycle the result is loaded.
  assign wr.en   = load && upd_wr;
  assign wr.addr = IDX_BITS'(req_q.proc);
  assign wr.data = ent_next;

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) state <= ST_CALC;
        end
        ST_CALC: begin
          if (load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_acc) req_q <= req;
    if (load)    rsp   <= rsp_calc;
  end

endmodule
`default_nettype wire

// ----- bench/per_process_time_accounting_tb.sv -----
`timescale 1ns / 100ps

module per_process_time_accounting_tb;
  import ppta_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RANDOM_ITEMS   = 1825;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned HOLD_AFTER     = 400;

  // Request types that the block does not know.
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  // Extremes of the event code field.
  localparam logic signed [15:0] EV_MIN_CODE = 16'sh8000;
  localparam logic signed [15:0] EV_MAX_CODE = 16'sh7FFF;

  localparam time_t TIME_MAX = '1;

  // Mirror of the per-process table plus the results it should produce.
  class acct_scoreboard;
    mode_t  mode_of[NUM_PROCS];
    time_t  since_of[NUM_PROCS];
    bit     tracing_of[NUM_PROCS];
    time_t  tracing_at[NUM_PROCS];
    time_t  elapsed_of[NUM_PROCS];
    time_t  traced_of[NUM_PROCS];
    time_t  flush_of[NUM_PROCS];
    time_t  useful_of[NUM_PROCS];
    time_t  critical_of[NUM_PROCS];
    err_t   first_err;
    rsp_t   expected_counts_q[$];
    int unsigned mismatches;
    int unsigned results_checked;

    function new();
      for (int i = 0; i < NUM_PROCS; i++) begin
        mode_of[i]     = MC_USEFUL;
        since_of[i]    = '0;
        tracing_of[i]  = 1'b1;
        tracing_at[i]  = '0;
        elapsed_of[i]  = '0;
        traced_of[i]   = '0;
        flush_of[i]    = '0;
        useful_of[i]   = '0;
        critical_of[i] = '0;
      end
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function int unsigned outstanding();
      return expected_counts_q.size();
    endfunction

    // Only the first error raised by a request is reported.
    function void note_error(err_t code);
      if (first_err == ERR_OK) first_err = code;
    endfunction

    function mode_t mode_for_event(logic signed [15:0] e);
      if (e == EV_USEFUL) return MC_USEFUL;
      if (e > EV_USEFUL) return MC_MPI;
      if (e == EV_END) return MC_END;
      if (e == EV_DISABLE) return MC_DISABLED;
      if (e == EV_FLUSH) return MC_FLUSH;
      if (e == EV_INIT) return MC_INIT;
      if (e == EV_INVALID) return MC_INVALID;
      return MC_MPI;
    endfunction

    // Credit the time spent in the mode being left.
    function void credit_span(int p, time_t t);
      time_t d;
      d = t - since_of[p];
      if (mode_of[p] == MC_USEFUL && tracing_of[p]) begin
        critical_of[p] = critical_of[p] + d;
        useful_of[p]   = useful_of[p] + d;
      end else if (mode_of[p] == MC_FLUSH) begin
        flush_of[p] = flush_of[p] + d;
      end else if (mode_of[p] == MC_END) begin
        note_error(ERR_AFTER_END);
      end
      if (tracing_of[p]) traced_of[p] = traced_of[p] + d;
    endfunction

    function void enter_mode(int p, time_t t, mode_t m);
      mode_of[p]    = m;
      since_of[p]   = t;
      elapsed_of[p] = t;
    endfunction

    // Apply an accepted item to the mirror and queue the result it causes.
    function void note_request(req_t it);
      int p;
      time_t t, d;
      logic signed [15:0] e;
      rsp_t r;
      p = it.proc;
      t = it.stamp;
      e = it.event_code;
      first_err = ERR_OK;
      if (p >= NUM_PROCS) begin
        r = '0;
        r.error_code = ERR_UNKNOWN;
        expected_counts_q.push_back(r);
        return;
      end
      case (it.req_type)
        REQ_START: begin
          if (tracing_of[p] && tracing_at[p] != it.trace_begin) note_error(ERR_REENABLE);
          tracing_of[p]  = 1'b1;
          tracing_at[p]  = it.trace_begin;
          critical_of[p] = t;
          traced_of[p]   = t;
          enter_mode(p, t, MC_USEFUL);
        end
        REQ_PLAY: begin
          if (e != EV_USEFUL) note_error(ERR_PLAY_EV);
          credit_span(p, t);
          if (!tracing_of[p]) begin
            tracing_of[p] = 1'b1;
            tracing_at[p] = t;
          end
          enter_mode(p, t, mode_for_event(e));
        end
        REQ_MPI_PAUSE: begin
          if (!tracing_of[p]) note_error(ERR_UNTRACED);
          if (mode_of[p] != MC_USEFUL && t != since_of[p]) note_error(ERR_REPAUSED);
          credit_span(p, t);
          enter_mode(p, t, mode_for_event(e));
        end
        REQ_TRC_PAUSE: begin
          credit_span(p, t);
          if (e == EV_INVALID) begin
            note_error(ERR_INVALID);
          end else if (e == EV_DISABLE) begin
            // Disabling turns tracing off even at time zero.
            if (tracing_of[p]) begin
              tracing_of[p] = 1'b0;
              tracing_at[p] = t;
            end
          end else if (e != EV_END && e != EV_FLUSH && e != EV_INIT) begin
            note_error(ERR_UNKNOWN);
          end
          enter_mode(p, t, mode_for_event(e));
        end
        REQ_END: begin
          d = t - since_of[p];
          if (mode_of[p] == MC_USEFUL) useful_of[p] = useful_of[p] + d;
          else if (mode_of[p] == MC_DISABLED)
            useful_of[p] = useful_of[p] + (it.universe_end - t);
          critical_of[p] = critical_of[p] + d;
          traced_of[p]   = traced_of[p] + d;
          enter_mode(p, t, MC_END);
        end
        default: begin
          note_error(ERR_UNKNOWN);
        end
      endcase
      r.elapsed_out  = elapsed_of[p];
      r.traced_out   = traced_of[p];
      r.flush_out    = flush_of[p];
      r.useful_out   = useful_of[p];
      r.critical_out = critical_of[p];
      r.error_code   = first_err;
      expected_counts_q.push_back(r);
    endfunction

    // Compare a result with the oldest expectation.
    function void check_result(rsp_t got);
      rsp_t want;
      results_checked++;
      if (expected_counts_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d: %p", results_checked, got);
        return;
      end
      want = expected_counts_q.pop_front();
      if (got.elapsed_out !== want.elapsed_out || got.traced_out !== want.traced_out ||
          got.flush_out !== want.flush_out || got.useful_out !== want.useful_out ||
          got.critical_out !== want.critical_out || got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d expected: elapsed %h traced %h flush %h useful %h crit %h err %0d",
                   results_checked, want.elapsed_out, want.traced_out, want.flush_out,
                   want.useful_out, want.critical_out, want.error_code);
          $display("result %0d actual:   elapsed %h traced %h flush %h useful %h crit %h err %0d",
                   results_checked, got.elapsed_out, got.traced_out, got.flush_out,
                   got.useful_out, got.critical_out, got.error_code);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  acct_scoreboard sb;
  int unsigned idle_cycles = 0;
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;

  // Stimulus bookkeeping per process: last stamp, last trace begin, ended.
  time_t next_stamp_of[NUM_PROCS];
  time_t tb_of[NUM_PROCS];
  bit    ended_of[NUM_PROCS];

  always #6 clk = ~clk;

  per_process_time_accounting DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap(bit no_idle);
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic time_t rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic signed [15:0] any_event();
    case ($urandom_range(0, 7))
      0: return EV_USEFUL;
      1: return EV_END;
      2: return EV_DISABLE;
      3: return EV_FLUSH;
      4: return EV_INIT;
      5: return EV_INVALID;
      6: return 16'($urandom_range(1, 32767));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random item, mostly plausible sequences on a few hot processes.
  function automatic req_t random_request();
    req_t it;
    int unsigned pick;
    logic [7:0] p;
    it = '0;
    p = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    it.proc = p;
    pick = $urandom_range(0, 99);
    if (ended_of[p] && $urandom_range(0, 99) < 70) it.req_type = REQ_START;
    else if (pick < 8) it.req_type = REQ_START;
    else if (pick < 38) it.req_type = REQ_PLAY;
    else if (pick < 64) it.req_type = REQ_MPI_PAUSE;
    else if (pick < 84) it.req_type = REQ_TRC_PAUSE;
    else if (pick < 94) it.req_type = REQ_END;
    else begin
      case ($urandom_range(0, 2))
        0: it.req_type = REQ_RSVD5;
        1: it.req_type = REQ_RSVD6;
        default: it.req_type = REQ_RSVD7;
      endcase
    end

    pick = $urandom_range(0, 99);
    if (pick < 78) it.stamp = next_stamp_of[p] + $urandom_range(1, 2000);
    else if (pick < 90) it.stamp = next_stamp_of[p];
    else if (pick < 96) it.stamp = rand48();
    else it.stamp = TIME_MAX - $urandom_range(0, 3000);
    next_stamp_of[p] = it.stamp;

    pick = $urandom_range(0, 99);
    case (it.req_type)
      REQ_PLAY: it.event_code = (pick < 80) ? EV_USEFUL : any_event();
      REQ_MPI_PAUSE: it.event_code = (pick < 70) ? 16'($urandom_range(1, 32767)) : any_event();
      REQ_TRC_PAUSE: begin
        if (pick < 80) begin
          case ($urandom_range(0, 3))
            0: it.event_code = EV_DISABLE;
            1: it.event_code = EV_END;
            2: it.event_code = EV_FLUSH;
            default: it.event_code = EV_INIT;
          endcase
        end else begin
          it.event_code = any_event();
        end
      end
      default: it.event_code = 16'($urandom);
    endcase

    if (it.req_type == REQ_START) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) it.trace_begin = tb_of[p];
      else if (pick < 80) it.trace_begin = it.stamp;
      else it.trace_begin = rand48();
      tb_of[p] = it.trace_begin;
      ended_of[p] = 1'b0;
    end else begin
      it.trace_begin = rand48();
    end
    if (it.req_type == REQ_END) ended_of[p] = 1'b1;

    if ($urandom_range(0, 99) < 60) it.universe_end = it.stamp + $urandom_range(0, 5000);
    else it.universe_end = rand48();
    return it;
  endfunction

  // Offer one item after a gap and hold it until the block takes it.
  task automatic drive_item(input req_t it, input int unsigned gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic directed_item(input logic [2:0] kind, input logic [7:0] p, input time_t t,
                               input logic signed [15:0] e, input time_t tb, input time_t ue);
    req_t it;
    it.req_type     = kind;
    it.proc         = p;
    it.stamp        = t;
    it.event_code   = e;
    it.trace_begin  = tb;
    it.universe_end = ue;
    drive_item(it, pick_gap(1'b0));
  endtask

  // Result side: random stalls, one long hold-off to fill the block up.
  initial begin
    int unsigned stall;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sb.results_checked >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 31) == 0) rx_no_idle = !rx_no_idle;
      stall = pick_gap(rx_no_idle);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Every result taken is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
  end

  // Give up when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sb = new();
    for (int i = 0; i < NUM_PROCS; i++) begin
      next_stamp_of[i] = '0;
      tb_of[i]         = '0;
      ended_of[i]      = 1'b0;
    end
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk one process through mode changes and most of the errors.
    directed_item(REQ_START, 8'd1, 48'd1000, EV_USEFUL, 48'd0, 48'd0);
    directed_item(REQ_PLAY, 8'd1, 48'd1500, EV_USEFUL, 48'd0, 48'd0);
    directed_item(REQ_MPI_PAUSE, 8'd1, 48'd2000, 16'sd12, 48'd0, 48'd0);
    directed_item(REQ_MPI_PAUSE, 8'd1, 48'd2000, 16'sd12, 48'd0, 48'd0);
    directed_item(REQ_MPI_PAUSE, 8'd1, 48'd2600, EV_MAX_CODE, 48'd0, 48'd0);
    directed_item(REQ_PLAY, 8'd1, 48'd3000, EV_FLUSH, 48'd0, 48'd0);
    directed_item(REQ_PLAY, 8'd1, 48'd3500, EV_USEFUL, 48'd0, 48'd0);
    directed_item(REQ_TRC_PAUSE, 8'd1, 48'd4000, EV_DISABLE, 48'd0, 48'd0);
    directed_item(REQ_END, 8'd1, 48'd4400, EV_USEFUL, 48'd0, 48'd9000);
    directed_item(REQ_MPI_PAUSE, 8'd1, 48'd4600, 16'sd3, 48'd0, 48'd0);
    directed_item(REQ_PLAY, 8'd1, 48'd5000, EV_USEFUL, 48'd0, 48'd0);
    directed_item(REQ_START, 8'd1, 48'd6000, EV_USEFUL, 48'd777, 48'd0);
    // Disable at time zero, then the trace pause codes and unknown requests.
    directed_item(REQ_TRC_PAUSE, 8'd2, 48'd0, EV_DISABLE, 48'd0, 48'd0);
    directed_item(REQ_START, 8'd2, 48'd10, EV_USEFUL, 48'd123, 48'd0);
    directed_item(REQ_TRC_PAUSE, 8'd2, 48'd50, EV_INVALID, 48'd0, 48'd0);
    directed_item(REQ_TRC_PAUSE, 8'd2, 48'd60, EV_END, 48'd0, 48'd0);
    directed_item(REQ_TRC_PAUSE, 8'd2, 48'd70, EV_INIT, 48'd0, 48'd0);
    directed_item(REQ_TRC_PAUSE, 8'd2, 48'd80, EV_MIN_CODE, 48'd0, 48'd0);
    directed_item(REQ_RSVD5, 8'd2, 48'd90, EV_USEFUL, 48'd0, 48'd0);
    directed_item(REQ_RSVD6, 8'd2, 48'd95, EV_MIN_CODE, TIME_MAX, TIME_MAX);
    directed_item(REQ_RSVD7, 8'd2, TIME_MAX, EV_MAX_CODE, 48'd0, 48'd0);
    // Field extremes and time that wraps around.
    directed_item(REQ_START, 8'd255, TIME_MAX, EV_USEFUL, TIME_MAX, TIME_MAX);
    directed_item(REQ_PLAY, 8'd255, 48'd5, EV_USEFUL, 48'd0, 48'd0);
    directed_item(REQ_TRC_PAUSE, 8'd255, 48'd9, EV_DISABLE, 48'd0, 48'd0);
    directed_item(REQ_END, 8'd255, 48'd0, EV_USEFUL, 48'd0, TIME_MAX);
    directed_item(REQ_MPI_PAUSE, 8'd0, TIME_MAX, EV_MAX_CODE, TIME_MAX, TIME_MAX);

    // Random part, with stretches of back-to-back items.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) == 0) tx_no_idle = !tx_no_idle;
      drive_item(random_request(), pick_gap(tx_no_idle));
    end
    req_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ppta_pkg.sv
src/ppta_mem.sv
src/ppta_update.sv
src/per_process_time_accounting.sv
bench/per_process_time_accounting_tb.sv
